[rtl/core/ffa_pkg.sv]
package ffa_pkg;

    // Command codes on the request channel
    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_STATUS = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_REQ = 2'd1;
    localparam logic [1:0] ST_NO_FIT  = 2'd2;
    localparam logic [1:0] ST_NO_BLK  = 2'd3;

    // Owner codes
    localparam logic [7:0] OWN_FREE   = 8'd0;
    localparam logic [7:0] OWN_KERNEL = 8'd1;

    // Beat widths
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 176;

    // One entry of the block table
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
        logic [7:0]  owner;
    } blk_entry_t;

endpackage

[rtl/core/ffa_tbl_mem.sv]
module ffa_tbl_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                   aclk,
    input  logic                   rd_en,
    input  logic [AW-1:0]          rd_addr,
    output ffa_pkg::blk_entry_t    rd_data,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  ffa_pkg::blk_entry_t    wr_data
);

    ffa_pkg::blk_entry_t mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/first_fit_heap_allocator.sv]
// First-fit heap allocator with coalescing.
// Requests arrive on the s_ channel (cmd, req_size, owner_id, data_offset);
// each request gives exactly one result beat on the m_ channel with the
// status, granted offset and heap statistics. The block table lives in a
// single-port-write, registered-read memory of MAX_BLOCKS entries; per-owner
// usage lives in a second memory of OWNER_SLOTS words with valid bits.
// One request at a time: a search walk over the table (one entry a cycle),
// for a split allocate a shift of the upper entries (a read state and a
// write state per entry), a usage read-modify-write (read, then write), then
// a rewrite walk that merges free neighbors and gathers statistics (one
// entry a cycle).
// The result sits in an output register; the next request is taken while it
// waits, but the following result holds until the receiver takes the beat.
// Reset and every write on the cfg port restart the heap as one free block spanning
// the arena after the statistics area (none if too small); no clearing pass is needed.
// Config writes are expected only while the block is idle.
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS   = 64,
    parameter int OWNER_SLOTS  = 256,
    parameter int HEADER_BYTES = 16,
    parameter int MIN_SPARE    = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // cfg: total_bytes
    input  logic                          cfg_wr_en,
    input  logic [31:0]                   cfg_wr_data,
    // s_tdata: cmd[1:0], req_size[33:2], owner_id[41:34], data_offset[73:42], zero pad
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ffa_pkg::S_DATA_W-1:0]  s_tdata,
    // m_tdata: status[1:0], grant_offset[33:2], used_bytes[65:34],
    // free_bytes[97:66], free_block_count[104:98], largest_free[136:105],
    // owner_bytes[168:137], zero pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ffa_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int OW = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
    localparam logic [31:0] RESET_TOTAL = 32'd1048576;
    localparam logic [32:0] STATS33     = 33'(OWNER_SLOTS * 4);
    localparam logic [32:0] H33         = 33'(HEADER_BYTES);
    localparam logic [33:0] H34         = 34'(HEADER_BYTES);
    localparam logic [31:0] H32         = 32'(HEADER_BYTES);
    localparam logic [32:0] SPLIT_MIN   = 33'(HEADER_BYTES + MIN_SPARE);
    localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_BLOCKS);
    localparam logic [8:0]  SLOTS9      = 9'(OWNER_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_HIT, S_SHRD, S_SHWR, S_SPLIT, S_SETHIT,
        S_URD, S_UWR, S_CMP, S_ORD, S_FIN
    } state_t;

    state_t state_reg;

    // request fields
    logic [1:0]  cmd_reg;
    logic [31:0] req_reg;
    logic [7:0]  own_reg;
    logic [31:0] off_reg;

    // heap state
    logic [CW-1:0] cnt_reg;
    logic [31:0]   used_reg;
    logic [31:0]   free_reg;
    logic [OWNER_SLOTS-1:0] use_vld_reg;

    // walk state
    logic [CW-1:0] idx_reg;
    logic [IW-1:0] pidx_reg;
    logic          pv_reg;
    logic [IW-1:0] hit_idx_reg;
    ffa_pkg::blk_entry_t hit_reg;
    logic [CW-1:0] j_reg;
    logic [31:0]   gsize_reg;
    ffa_pkg::blk_entry_t pend_reg;
    logic          have_reg;
    logic [CW-1:0] w_reg;
    logic [6:0]    nfree_reg;
    logic [31:0]   largest_reg;

    // usage update
    logic [OW-1:0] uslot_reg;
    logic [31:0]   uamt_reg;
    logic          uadd_reg;

    // result
    logic [1:0]    status_reg;
    logic [31:0]   grant_reg;
    logic          m_valid_reg;
    logic [ffa_pkg::M_DATA_W-1:0] m_data_reg;

    // table memory ports
    logic                rd_en;
    logic [IW-1:0]       rd_addr;
    ffa_pkg::blk_entry_t rd_q;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    ffa_pkg::blk_entry_t wr_data;

    // usage memory
    logic [31:0]   use_mem [OWNER_SLOTS];
    logic [31:0]   use_q;
    logic          use_rd_en;
    logic [OW-1:0] use_rd_addr;
    logic          use_wr_en;
    logic [31:0]   use_new;

    // restart values
    logic [31:0]   tot_src;
    logic          tot_fits;
    ffa_pkg::blk_entry_t init_entry;

    // derived
    logic        restart;
    logic        s_fire;
    logic [1:0]  s_cmd;
    logic [31:0] s_req;
    logic [7:0]  s_own;
    logic [31:0] s_off;
    logic        match;
    logic        merge;
    logic [31:0] spare;
    logic        split;
    logic        perm_ok;
    logic        own_in;
    logic        holder_in;
    logic [7:0]  pend_cnt_dummy;
    logic [31:0] pend_merged;

    assign restart  = !aresetn || cfg_wr_en;
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign s_cmd    = s_tdata[1:0];
    assign s_req    = s_tdata[33:2];
    assign s_own    = s_tdata[41:34];
    assign s_off    = s_tdata[73:42];

    assign tot_src  = aresetn ? cfg_wr_data : RESET_TOTAL;
    assign tot_fits = {1'b0, tot_src} >= (STATS33 + H33);
    assign init_entry.start = STATS33[31:0];
    assign init_entry.size  = tot_src - STATS33[31:0] - H32;
    assign init_entry.owner = ffa_pkg::OWN_FREE;

    // Compare the entry just read against the request
    always_comb begin
        if (cmd_reg == ffa_pkg::CMD_ALLOC) begin
            match = pv_reg && (rd_q.owner == ffa_pkg::OWN_FREE) && (rd_q.size >= req_reg);
        end else begin
            match = pv_reg && (({1'b0, rd_q.start} + H33) == {1'b0, off_reg});
        end
    end

    assign merge = (pend_reg.owner == ffa_pkg::OWN_FREE) && (rd_q.owner == ffa_pkg::OWN_FREE)
                && (({2'b0, pend_reg.start} + H34 + {2'b0, pend_reg.size})
                    == {2'b0, rd_q.start});
    assign pend_merged = pend_reg.size + H32 + rd_q.size;

    assign spare   = hit_reg.size - req_reg;
    assign split   = ({1'b0, spare} >= SPLIT_MIN) && (cnt_reg < MAX_CNT);
    assign perm_ok = (own_reg == ffa_pkg::OWN_KERNEL) ? (hit_reg.owner == ffa_pkg::OWN_KERNEL)
                                                      : (hit_reg.owner > ffa_pkg::OWN_KERNEL);
    assign own_in    = {1'b0, own_reg} < SLOTS9;
    assign holder_in = {1'b0, hit_reg.owner} < SLOTS9;
    assign pend_cnt_dummy = pend_reg.owner;

    // Table memory address and write selection
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = idx_reg[IW-1:0];
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = pend_reg;
        if (restart) begin
            wr_en   = 1'b1;
            wr_data = init_entry;
        end else begin
            unique case (state_reg)
                S_SCAN: begin
                    rd_en = (idx_reg < cnt_reg) && !match;
                end
                S_HIT: begin
                    if (cmd_reg == ffa_pkg::CMD_FREE && perm_ok
                        && hit_reg.owner != ffa_pkg::OWN_FREE) begin
                        wr_en         = 1'b1;
                        wr_addr       = hit_idx_reg;
                        wr_data       = hit_reg;
                        wr_data.owner = ffa_pkg::OWN_FREE;
                    end
                end
                S_SHRD: begin
                    rd_en   = j_reg > (CW'(hit_idx_reg) + CW'(1));
                    rd_addr = IW'(j_reg - CW'(1));
                end
                S_SHWR: begin
                    wr_en   = 1'b1;
                    wr_addr = j_reg[IW-1:0];
                    wr_data = rd_q;
                end
                S_SPLIT: begin
                    wr_en         = 1'b1;
                    wr_addr       = hit_idx_reg + IW'(1);
                    wr_data.start = hit_reg.start + H32 + req_reg;
                    wr_data.size  = spare - H32;
                    wr_data.owner = ffa_pkg::OWN_FREE;
                end
                S_SETHIT: begin
                    wr_en         = 1'b1;
                    wr_addr       = hit_idx_reg;
                    wr_data.start = hit_reg.start;
                    wr_data.size  = gsize_reg;
                    wr_data.owner = own_reg;
                end
                S_CMP: begin
                    rd_en   = idx_reg < cnt_reg;
                    wr_addr = w_reg[IW-1:0];
                    if (pv_reg) begin
                        wr_en = have_reg && !merge;
                    end else begin
                        wr_en = (idx_reg >= cnt_reg) && have_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    ffa_tbl_mem #(
        .DEPTH (MAX_BLOCKS),
        .AW    (IW)
    ) u_tbl (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_q),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Usage memory access
    assign use_rd_en   = (state_reg == S_URD) || (state_reg == S_ORD);
    assign use_rd_addr = (state_reg == S_URD) ? uslot_reg : own_reg[OW-1:0];
    assign use_wr_en   = (state_reg == S_UWR) && !restart;
    always_comb begin
        if (use_vld_reg[uslot_reg]) begin
            use_new = uadd_reg ? (use_q + uamt_reg) : (use_q - uamt_reg);
        end else begin
            use_new = uadd_reg ? uamt_reg : (32'd0 - uamt_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (use_wr_en) begin
            use_mem[uslot_reg] <= use_new;
        end
        if (use_rd_en) begin
            use_q <= use_mem[use_rd_addr];
        end
    end

    // Count an entry that leaves the rewrite walk as a free block, saturating at 127
    function automatic logic [6:0] nfree_add(input logic [6:0] n, input logic is_free);
        logic [6:0] r;
        r = n;
        if (is_free && n != 7'd127) begin
            r = n + 7'd1;
        end
        return r;
    endfunction

    // Control state machine and registered outputs
    always_ff @(posedge aclk) begin
        if (restart) begin
            cnt_reg     <= tot_fits ? CW'(1) : '0;
            used_reg    <= '0;
            free_reg    <= tot_src;
            use_vld_reg <= '0;
        end
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            pv_reg      <= 1'b0;
        end else begin
            pv_reg <= (state_reg == S_SCAN || state_reg == S_CMP) ? rd_en : 1'b0;
            // Drop the beat once taken; the final state reloads it itself
            if (m_valid_reg && m_tready && state_reg != S_FIN) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        cmd_reg     <= s_cmd;
                        req_reg     <= s_req;
                        own_reg     <= s_own;
                        off_reg     <= s_off;
                        grant_reg   <= '0;
                        idx_reg     <= '0;
                        have_reg    <= 1'b0;
                        w_reg       <= '0;
                        nfree_reg   <= '0;
                        largest_reg <= '0;
                        status_reg  <= ffa_pkg::ST_OK;
                        state_reg   <= S_CMP;
                        if (s_cmd == ffa_pkg::CMD_ALLOC) begin
                            if (s_req == '0 || s_own == ffa_pkg::OWN_FREE) begin
                                status_reg <= ffa_pkg::ST_BAD_REQ;
                            end else begin
                                state_reg <= S_SCAN;
                            end
                        end else if (s_cmd == ffa_pkg::CMD_FREE) begin
                            if (s_own == ffa_pkg::OWN_FREE) begin
                                status_reg <= ffa_pkg::ST_BAD_REQ;
                            end else begin
                                state_reg <= S_SCAN;
                            end
                        end else if (s_cmd != ffa_pkg::CMD_STATUS) begin
                            status_reg <= ffa_pkg::ST_BAD_REQ;
                        end
                    end
                end
                S_SCAN: begin
                    pidx_reg <= idx_reg[IW-1:0];
                    if (rd_en) begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                    if (match) begin
                        hit_idx_reg <= pidx_reg;
                        hit_reg     <= rd_q;
                        state_reg   <= S_HIT;
                    end else if (!pv_reg && idx_reg >= cnt_reg) begin
                        status_reg <= (cmd_reg == ffa_pkg::CMD_ALLOC) ? ffa_pkg::ST_NO_FIT
                                                                      : ffa_pkg::ST_NO_BLK;
                        idx_reg    <= '0;
                        state_reg  <= S_CMP;
                    end
                end
                S_HIT: begin
                    idx_reg <= '0;
                    if (cmd_reg == ffa_pkg::CMD_ALLOC) begin
                        gsize_reg <= split ? req_reg : hit_reg.size;
                        j_reg     <= cnt_reg;
                        state_reg <= split ? S_SHRD : S_SETHIT;
                    end else if (!perm_ok || hit_reg.owner == ffa_pkg::OWN_FREE) begin
                        status_reg <= ffa_pkg::ST_NO_BLK;
                        state_reg  <= S_CMP;
                    end else begin
                        used_reg  <= used_reg - (hit_reg.size + H32);
                        free_reg  <= free_reg + (hit_reg.size + H32);
                        uslot_reg <= hit_reg.owner[OW-1:0];
                        uamt_reg  <= hit_reg.size;
                        uadd_reg  <= 1'b0;
                        state_reg <= holder_in ? S_URD : S_CMP;
                    end
                end
                S_SHRD: begin
                    state_reg <= rd_en ? S_SHWR : S_SPLIT;
                end
                S_SHWR: begin
                    j_reg     <= j_reg - CW'(1);
                    state_reg <= S_SHRD;
                end
                S_SPLIT: begin
                    cnt_reg   <= cnt_reg + CW'(1);
                    state_reg <= S_SETHIT;
                end
                S_SETHIT: begin
                    used_reg  <= used_reg + (gsize_reg + H32);
                    free_reg  <= free_reg - (gsize_reg + H32);
                    grant_reg <= hit_reg.start + H32;
                    uslot_reg <= own_reg[OW-1:0];
                    uamt_reg  <= gsize_reg;
                    uadd_reg  <= 1'b1;
                    state_reg <= own_in ? S_URD : S_CMP;
                end
                S_URD: begin
                    state_reg <= S_UWR;
                end
                S_UWR: begin
                    use_vld_reg[uslot_reg] <= 1'b1;
                    state_reg              <= S_CMP;
                end
                S_CMP: begin
                    if (rd_en) begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                    if (pv_reg) begin
                        if (!have_reg) begin
                            pend_reg <= rd_q;
                            have_reg <= 1'b1;
                        end else if (merge) begin
                            pend_reg.size <= pend_merged;
                        end else begin
                            w_reg     <= w_reg + CW'(1);
                            nfree_reg <= nfree_add(nfree_reg,
                                                   pend_cnt_dummy == ffa_pkg::OWN_FREE);
                            if (pend_reg.owner == ffa_pkg::OWN_FREE
                                && pend_reg.size > largest_reg) begin
                                largest_reg <= pend_reg.size;
                            end
                            pend_reg <= rd_q;
                        end
                    end else if (idx_reg >= cnt_reg) begin
                        if (have_reg) begin
                            cnt_reg   <= w_reg + CW'(1);
                            nfree_reg <= nfree_add(nfree_reg,
                                                   pend_reg.owner == ffa_pkg::OWN_FREE);
                            if (pend_reg.owner == ffa_pkg::OWN_FREE
                                && pend_reg.size > largest_reg) begin
                                largest_reg <= pend_reg.size;
                            end
                        end else begin
                            cnt_reg <= '0;
                        end
                        state_reg <= S_ORD;
                    end
                end
                S_ORD: begin
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {7'd0,
                                        (own_in && use_vld_reg[own_reg[OW-1:0]]) ? use_q : 32'd0,
                                        largest_reg, nfree_reg, free_reg, used_reg,
                                        grant_reg, status_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // The table never holds more entries than it has room for
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= MAX_CNT)
        else $error("block count beyond table depth");

    // A config write restarts accounting
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> (used_reg == '0) && (cnt_reg <= CW'(1)))
        else $error("heap restart did not clear accounting");

    // Read data is only consumed by the walking states
    a_pv_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        pv_reg |-> (state_reg == S_SCAN || state_reg == S_CMP))
        else $error("table read pending outside a walk");

    // A result is loaded only from the final state
    a_res_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result raised outside final state");

endmodule

[tb/sv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBLK = 64;
    localparam int NOWN = 256;
    localparam int HDR = 16;
    localparam int SPARE_MIN = 8;
    localparam int STATS_AREA = NOWN * 4;
    localparam int WATCHDOG = 20000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] grant;
        logic [31:0] used;
        logic [31:0] free;
        logic [6:0]  nfree;
        logic [31:0] largest;
        logic [31:0] owner_bytes;
    } heap_result_t;

    // Heap predictor and queue of expected result beats
    class heap_scoreboard;
        logic [31:0] arena;
        logic [31:0] bstart [NBLK];
        logic [31:0] bsize [NBLK];
        logic [7:0]  bowner [NBLK];
        int nblk;
        logic [31:0] used_sum, free_sum;
        logic [31:0] per_owner [NOWN];
        heap_result_t pending[$];
        int mismatches;
        logic [31:0] live_offsets[$];

        function void restart(logic [31:0] bytes);
            arena = bytes;
            used_sum = 0;
            free_sum = bytes;
            nblk = 0;
            live_offsets.delete();
            for (int i = 0; i < NOWN; i++) per_owner[i] = 0;
            for (int i = 0; i < NBLK; i++) begin
                bstart[i] = 0; bsize[i] = 0; bowner[i] = 0;
            end
            if (longint'(bytes) >= STATS_AREA + HDR) begin
                bstart[0] = STATS_AREA;
                bsize[0] = bytes - STATS_AREA - HDR;
                nblk = 1;
            end
        endfunction

        function void drop_entry(int k);
            for (int j = k; j + 1 < nblk; j++) begin
                bstart[j] = bstart[j+1]; bsize[j] = bsize[j+1]; bowner[j] = bowner[j+1];
            end
            nblk--;
        endfunction

        function logic [1:0] allocate(logic [31:0] sz, logic [7:0] own,
                                      output logic [31:0] grant);
            logic [31:0] spare;
            grant = 0;
            if (sz == 0 || own == 0) return ffa_pkg::ST_BAD_REQ;
            for (int i = 0; i < nblk; i++) begin
                if (bowner[i] == ffa_pkg::OWN_FREE && bsize[i] >= sz) begin
                    spare = bsize[i] - sz;
                    if (longint'(spare) >= HDR + SPARE_MIN && nblk < NBLK) begin
                        for (int j = nblk; j > i + 1; j--) begin
                            bstart[j] = bstart[j-1]; bsize[j] = bsize[j-1];
                            bowner[j] = bowner[j-1];
                        end
                        bstart[i+1] = bstart[i] + HDR + sz;
                        bsize[i+1] = spare - HDR;
                        bowner[i+1] = ffa_pkg::OWN_FREE;
                        nblk++;
                        bsize[i] = sz;
                    end
                    bowner[i] = own;
                    used_sum += bsize[i] + HDR;
                    free_sum -= bsize[i] + HDR;
                    per_owner[own] += bsize[i];
                    grant = bstart[i] + HDR;
                    live_offsets.push_back(grant);
                    return ffa_pkg::ST_OK;
                end
            end
            return ffa_pkg::ST_NO_FIT;
        endfunction

        function logic [1:0] release_block(logic [31:0] offs, logic [7:0] own);
            logic [7:0] holder;
            int i;
            if (own == 0) return ffa_pkg::ST_BAD_REQ;
            for (i = 0; i < nblk; i++) begin
                if (longint'(bstart[i]) + HDR == longint'(offs)) begin
                    holder = bowner[i];
                    if (own == ffa_pkg::OWN_KERNEL ? holder != ffa_pkg::OWN_KERNEL
                                                   : holder <= 1)
                        return ffa_pkg::ST_NO_BLK;
                    used_sum -= bsize[i] + HDR;
                    free_sum += bsize[i] + HDR;
                    per_owner[holder] -= bsize[i];
                    bowner[i] = ffa_pkg::OWN_FREE;
                    // merge adjacent free neighbors
                    i = 0;
                    while (i + 1 < nblk) begin
                        if (bowner[i] == 0 && bowner[i+1] == 0 &&
                            longint'(bstart[i]) + HDR + bsize[i] == longint'(bstart[i+1])) begin
                            bsize[i] = bsize[i] + HDR + bsize[i+1];
                            drop_entry(i + 1);
                        end else begin
                            i++;
                        end
                    end
                    return ffa_pkg::ST_OK;
                end
            end
            return ffa_pkg::ST_NO_BLK;
        endfunction

        function void note_request(logic [1:0] cmd, logic [31:0] sz, logic [7:0] own,
                                   logic [31:0] offs);
            heap_result_t r;
            int cnt;
            r = '0;
            if (cmd == ffa_pkg::CMD_ALLOC) r.status = allocate(sz, own, r.grant);
            else if (cmd == ffa_pkg::CMD_FREE) r.status = release_block(offs, own);
            else if (cmd == ffa_pkg::CMD_STATUS) r.status = ffa_pkg::ST_OK;
            else r.status = ffa_pkg::ST_BAD_REQ;
            cnt = 0;
            for (int i = 0; i < nblk; i++) begin
                if (bowner[i] == ffa_pkg::OWN_FREE) begin
                    cnt++;
                    if (bsize[i] > r.largest) r.largest = bsize[i];
                end
            end
            r.nfree = cnt > 127 ? 7'd127 : 7'(cnt);
            r.used = used_sum;
            r.free = free_sum;
            r.owner_bytes = per_owner[own];
            pending.push_back(r);
        endfunction

        function void check_result(heap_result_t got);
            heap_result_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch (exp/act): st %0d/%0d grant %h/%h",
                             want.status, got.status, want.grant, got.grant,
                             " used %h/%h free %h/%h nfree %0d/%0d",
                             want.used, got.used, want.free, got.free,
                             want.nfree, got.nfree,
                             " largest %h/%h own %h/%h",
                             want.largest, got.largest, want.owner_bytes,
                             got.owner_bytes);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [31:0] cfg_wr_data = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [ffa_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [ffa_pkg::M_DATA_W-1:0] m_tdata;

    heap_scoreboard heap = new();
    int idle_cycles = 0;
    int hold_off = 0;
    bit hold_req = 0;

    always #5 aclk = ~aclk;

    first_fit_heap_allocator uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Check result beats and count cycles without any handshake
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            heap.check_result({m_tdata[1:0], m_tdata[33:2], m_tdata[65:34], m_tdata[97:66],
                               m_tdata[104:98], m_tdata[136:105], m_tdata[168:137]});
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off on request
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 0;
                repeat (hold_off) @(negedge aclk);
                hold_req = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_beat(logic [1:0] cmd, logic [31:0] sz, logic [7:0] own,
                             logic [31:0] offs, bit no_gap = 0);
        int gap;
        gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap - 1) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {6'b0, offs, own, sz, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        heap.note_request(cmd, sz, own, offs);
        @(negedge aclk);
        s_tvalid <= 0;
    endtask

    task automatic drain();
        while (heap.pending.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    task automatic write_total(logic [31:0] bytes);
        drain();
        @(negedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= bytes;
        @(negedge aclk);
        cfg_wr_en <= 0;
        heap.restart(bytes);
    endtask

    function automatic logic [7:0] pick_owner();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r < 6) return ffa_pkg::OWN_KERNEL;
        return 8'($urandom_range(2, 255));
    endfunction

    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return $urandom();
        if (r == 1) return 0;
        if (r < 10) return $urandom_range(1, 64);
        return $urandom_range(1, 4096);
    endfunction

    // Allocations and frees (mostly of live blocks, some random offsets), few other commands
    task automatic random_phase(int count);
        logic [31:0] offs;
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                send_beat(ffa_pkg::CMD_ALLOC, pick_size(), pick_owner(), $urandom());
            end else if (r < 90) begin
                if (heap.live_offsets.size() > 0 && r < 85) begin
                    int k;
                    k = $urandom_range(0, heap.live_offsets.size() - 1);
                    offs = heap.live_offsets[k];
                    heap.live_offsets.delete(k);
                end else begin
                    offs = $urandom();
                end
                send_beat(ffa_pkg::CMD_FREE, $urandom(), pick_owner(), offs);
            end else begin
                send_beat(r < 97 ? ffa_pkg::CMD_STATUS : CMD_UNUSED, $urandom(),
                          8'($urandom()), $urandom());
            end
        end
    endtask

    initial begin
        heap.restart(32'd1048576);
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Directed: bad requests, extremes, permission and merges
        send_beat(ffa_pkg::CMD_STATUS, 0, 0, 0);
        send_beat(ffa_pkg::CMD_ALLOC, 0, 5, 0);
        send_beat(ffa_pkg::CMD_ALLOC, 100, 0, 0);
        send_beat(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        send_beat(ffa_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 8'hFF, 0);
        send_beat(ffa_pkg::CMD_ALLOC, 100, ffa_pkg::OWN_KERNEL, 0);
        send_beat(ffa_pkg::CMD_ALLOC, 200, 8'd255, 0);
        send_beat(ffa_pkg::CMD_ALLOC, 1, 8'd2, 0);
        send_beat(ffa_pkg::CMD_FREE, 0, 8'd2, STATS_AREA + HDR);
        send_beat(ffa_pkg::CMD_FREE, 0, 0, STATS_AREA + HDR);
        send_beat(ffa_pkg::CMD_FREE, 0, 8'd7, STATS_AREA + HDR + 116);
        send_beat(ffa_pkg::CMD_FREE, 0, 8'd7, STATS_AREA + HDR + 116);
        send_beat(ffa_pkg::CMD_FREE, 0, ffa_pkg::OWN_KERNEL, STATS_AREA + HDR + 232);
        send_beat(ffa_pkg::CMD_FREE, 0, ffa_pkg::OWN_KERNEL, STATS_AREA + HDR);
        send_beat(ffa_pkg::CMD_FREE, 0, 8'd3, 32'hFFFF_FFFF);
        send_beat(ffa_pkg::CMD_FREE, 0, 8'd3, STATS_AREA + HDR + 232);
        send_beat(ffa_pkg::CMD_STATUS, 0, 8'd255, 0);

        // Tiny arena, then one that just fits a header
        write_total(32'd0);
        send_beat(ffa_pkg::CMD_ALLOC, 1, ffa_pkg::OWN_KERNEL, 0);
        write_total(STATS_AREA + HDR);
        send_beat(ffa_pkg::CMD_ALLOC, 1, 8'd9, 0);
        send_beat(ffa_pkg::CMD_STATUS, 0, 8'd9, 0);

        // Small arena so the table fills up; exact fit with no split
        write_total(32'd4000);
        random_phase(120);
        // Table full: many tiny allocations in a large arena
        write_total(32'd65536);
        for (int n = 0; n < 70; n++)
            send_beat(ffa_pkg::CMD_ALLOC, 8, pick_owner() | 8'd1, 0, 1);
        random_phase(60);

        // Long receiver hold-off while requests keep coming
        drain();
        hold_off = 400;
        hold_req = 1;
        for (int n = 0; n < 12; n++)
            send_beat(ffa_pkg::CMD_STATUS, 0, 8'($urandom()), 0, 1);

        write_total(32'hFFFF_FFFF);
        send_beat(ffa_pkg::CMD_ALLOC, 32'hFFFF_F000, 8'd200, 0);
        random_phase(120);
        write_total(32'd1048576);
        random_phase(150);

        drain();
        if (heap.mismatches == 0 && heap.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
